FILE: design/sact_pkg.sv
// Package for the set-associative cache tag lookup core.
// Holds widths, register indexes, the controller command and status types.
`default_nettype none
package sact_pkg;
  localparam int unsigned TAG_W = 27;
  localparam int unsigned RANK_W = 10;
  localparam logic [RANK_W-1:0] RANK_MAX = 10'd1023;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_LOG2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd3;
  localparam logic POLICY_FIFO = 1'b0;

  typedef struct packed {
    logic clear;
    logic start;
    logic search;
    logic choose;
    logic age;
    logic commit;
    logic out_load;
  } sact_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic last_way;
    logic hit_found;
    logic out_busy;
  } sact_sts_t;
endpackage
`default_nettype wire

FILE: design/sact_if.sv
// Valid/ready channel interface used on both sides of the core.
// Depends on nothing; width set by parameter.
`default_nettype none
interface sact_if #(parameter int unsigned W = 32);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/sact_ctrl.sv
// Controller state machine of the tag lookup core.
// Depends on sact_pkg; drives commands into sact_dp.
`default_nettype none
module sact_ctrl
  import sact_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  output logic      in_rdy,
  input  sact_sts_t sts,
  output sact_cmd_t cmd
);
  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_SEARCH = 7'b0000100,
    ST_CHOOSE = 7'b0001000,
    ST_AGE    = 7'b0010000,
    ST_COMMIT = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    cmd = '0;
    in_rdy = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          cmd.start = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (sts.hit_found) state_nxt = ST_AGE;
        else if (sts.last_way) state_nxt = ST_CHOOSE;
      end
      ST_CHOOSE: begin
        cmd.choose = 1'b1;
        if (sts.last_way) state_nxt = ST_AGE;
      end
      ST_AGE: begin
        cmd.age = 1'b1;
        if (sts.last_way) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end
endmodule
`default_nettype wire

FILE: design/sact_dp.sv
// Datapath of the tag lookup core: tag, valid, rank and pointer stores,
// way search, victim choice, rank ageing and counters. Depends on sact_pkg.
`default_nettype none
module sact_dp
  import sact_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 1024,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [31:0] in_addr,
  input  wire logic        cfg_policy,
  input  wire logic [3:0]  cfg_wl,
  input  wire logic [3:0]  cfg_bl,
  input  wire logic [2:0]  cfg_ob,
  input  sact_cmd_t        cmd,
  output sact_sts_t        sts,
  input  wire logic        out_take,
  output logic             out_vld,
  output logic [64:0]      out_payload
);
  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned AW = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;

  logic [TAG_W-1:0]  tag_mem [MAX_BLOCKS];
  logic              vld_mem [MAX_BLOCKS];
  logic [RANK_W-1:0] rank_mem [MAX_BLOCKS];
  logic [IDX_W-1:0]  ptr_mem [MAX_BLOCKS];

  logic [IDX_W-1:0]  base_r, set_r, victim_r, way_r, best_way_r;
  logic [IDX_W-1:0]  wmask_r;
  logic [TAG_W-1:0]  tag_r;
  logic [RANK_W-1:0] best_r, old_r, fifo_rank_r;
  logic              old_inv_r, inv_found_r, hit_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [31:0]       hits_r, misses_r;
  logic [TAG_W-1:0]  rd_tag_r;
  logic              rd_vld_r;
  logic [RANK_W-1:0] rd_rank_r;
  logic [IDX_W-1:0]  ptr_rd_r;
  logic [IDX_W-1:0]  cur;
  logic [IDX_W-1:0]  rd_ptr;
  logic [IDX_W-1:0]  way_nxt, rd_addr, start_set, start_base;
  logic              out_vld_r;
  logic [64:0]       out_r;
  logic [3:0]        bl, wl, sl;
  logic [31:0]       a, a_sh;
  logic [IDX_W-1:0]  smask;

  assign bl = (cfg_bl > 4'(IDX_W)) ? 4'(IDX_W) : cfg_bl;
  assign wl = (cfg_wl > bl) ? bl : cfg_wl;
  assign sl = bl - wl;
  assign a = 32'(in_addr[AW-1:0]);
  assign a_sh = a >> cfg_ob;
  assign smask = IDX_W'((CNT_W'(1) << sl) - CNT_W'(1));
  assign start_set = a_sh[IDX_W-1:0] & smask;
  assign start_base = IDX_W'(start_set << wl);
  assign cur = base_r + way_r;
  assign rd_ptr = ptr_rd_r & wmask_r;
  assign sts.last_way = (way_r == wmask_r);
  assign sts.hit_found = rd_vld_r && (rd_tag_r == tag_r);
  assign sts.clear_done = (cnt_r == CNT_W'(MAX_BLOCKS - 1));
  assign sts.out_busy = out_vld_r && !out_take;
  assign out_vld = out_vld_r;
  assign out_payload = out_r;

  // The stores are read one way ahead, so the registered data always belongs
  // to the way that the current pass is looking at.
  always_comb begin
    if (cmd.start) way_nxt = '0;
    else if (cmd.search) way_nxt = (sts.hit_found || sts.last_way) ? '0 : way_r + 1'b1;
    else if (cmd.choose) way_nxt = sts.last_way ? '0 : way_r + 1'b1;
    else if (cmd.age) way_nxt = sts.last_way ? way_r : way_r + 1'b1;
    else way_nxt = way_r;
  end

  assign rd_addr = cmd.start ? start_base : base_r + way_nxt;

  always_ff @(posedge clk) begin
    rd_tag_r <= tag_mem[rd_addr];
    rd_vld_r <= vld_mem[rd_addr];
    rd_rank_r <= rank_mem[rd_addr];
    ptr_rd_r <= ptr_mem[set_r];
    if (cmd.clear) begin
      vld_mem[cnt_r[IDX_W-1:0]] <= 1'b0;
      rank_mem[cnt_r[IDX_W-1:0]] <= '0;
      ptr_mem[cnt_r[IDX_W-1:0]] <= '0;
    end
    if (cmd.age && cur != victim_r && rd_vld_r && (old_inv_r || rd_rank_r < old_r)
        && rd_rank_r < RANK_MAX)
      rank_mem[cur] <= rd_rank_r + 1'b1;
    if (cmd.commit) begin
      rank_mem[victim_r] <= '0;
      if (!hit_r) begin
        tag_mem[victim_r] <= tag_r;
        vld_mem[victim_r] <= 1'b1;
        if (!inv_found_r && cfg_policy == POLICY_FIFO)
          ptr_mem[set_r] <= (rd_ptr + 1'b1) & wmask_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      hits_r <= '0;
      misses_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.clear) cnt_r <= cnt_r + 1'b1;
      if (cmd.out_load) out_vld_r <= 1'b1;
      else if (out_take) out_vld_r <= 1'b0;
      if (cmd.commit) begin
        if (hit_r) hits_r <= (hits_r == '1) ? hits_r : hits_r + 1'b1;
        else misses_r <= (misses_r == '1) ? misses_r : misses_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    way_r <= way_nxt;
    if (cmd.out_load) out_r <= {hit_r, hits_r, misses_r};
    if (cmd.start) begin
      set_r <= start_set;
      base_r <= start_base;
      wmask_r <= IDX_W'((CNT_W'(1) << wl) - CNT_W'(1));
      tag_r <= TAG_W'(a_sh >> sl);
      hit_r <= 1'b0;
      inv_found_r <= 1'b0;
      best_r <= '0;
      best_way_r <= '0;
    end
    if (cmd.search) begin
      if (sts.hit_found) begin
        hit_r <= 1'b1;
        victim_r <= cur;
        old_r <= rd_rank_r;
        old_inv_r <= 1'b0;
      end
    end
    if (cmd.choose) begin
      if (way_r == rd_ptr) fifo_rank_r <= rd_rank_r;
      if (!inv_found_r && !rd_vld_r) begin
        inv_found_r <= 1'b1;
        best_way_r <= cur;
      end
      if (rd_rank_r > best_r) begin
        best_r <= rd_rank_r;
        if (!inv_found_r && rd_vld_r) best_way_r <= cur;
      end
      if (sts.last_way) begin
        if (!inv_found_r && !rd_vld_r) begin
          victim_r <= cur;
          old_inv_r <= 1'b1;
        end else if (inv_found_r) begin
          victim_r <= best_way_r;
          old_inv_r <= 1'b1;
        end else if (cfg_policy == POLICY_FIFO) begin
          victim_r <= base_r + rd_ptr;
          old_inv_r <= 1'b0;
          old_r <= (way_r == rd_ptr) ? rd_rank_r : fifo_rank_r;
        end else if (rd_rank_r > best_r) begin
          victim_r <= cur;
          old_inv_r <= 1'b0;
          old_r <= rd_rank_r;
        end else begin
          victim_r <= (best_r == '0) ? base_r : best_way_r;
          old_inv_r <= 1'b0;
          old_r <= best_r;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/set_assoc_cache_tag_lookup_core.sv
// Set-associative cache tag lookup: one address in, one hit/count item out.
// Usage: in_ carries a 32-bit byte address; out_ carries hit, hit_total and
// miss_total. cfg_ writes policy, ways_log2, blocks_log2 and offset_bits.
// Each item walks the ways of its set one per cycle, through one read port
// and one write port on the tag, valid and rank stores: a search pass until
// the first hit (or all ways on a miss), a victim pass on a miss, and an
// ageing pass. One item is in flight at a time.
// After reset a clearing pass over all MAX_BLOCKS entries resets valid bits,
// ranks and round-robin pointers; no item is taken until it ends.
// The result sits in an output register; if the receiver stalls, the next
// item is taken and worked on but its result waits until the register frees.
// Counts saturate at their maximum. Configuration changes keep the contents.
`default_nettype none
module set_assoc_cache_tag_lookup_core
  import sact_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 1024,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  sact_if.sink                       in_ch,
  sact_if.source                     out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  logic policy_r;
  logic [3:0] wl_r, bl_r;
  logic [2:0] ob_r;
  sact_cmd_t cmd;
  sact_sts_t sts;
  logic in_rdy, in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= 1'b0;
      wl_r <= 4'd0;
      bl_r <= 4'd10;
      ob_r <= 3'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLICY: policy_r <= cfg_data[0];
        REG_WAYS_LOG2: wl_r <= cfg_data;
        REG_BLOCKS_LOG2: bl_r <= cfg_data;
        REG_OFFSET_BITS: ob_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = in_rdy;
  assign in_fire = in_ch.valid && in_rdy;

  sact_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_rdy(in_rdy),
    .sts(sts), .cmd(cmd)
  );

  sact_dp #(.MAX_BLOCKS(MAX_BLOCKS), .ADDR_WIDTH(ADDR_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_addr(in_ch.data), .cfg_policy(policy_r),
    .cfg_wl(wl_r), .cfg_bl(bl_r), .cfg_ob(ob_r), .cmd(cmd), .sts(sts),
    .out_take(out_ch.ready), .out_vld(out_ch.valid), .out_payload(out_ch.data)
  );

`ifndef SYNTHESIS
  a_one_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.search, cmd.choose, cmd.age, cmd.commit}))
    else $error("more than one pass active");
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_ch.valid && !out_ch.ready))
    else $error("result overwritten");
  a_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> cmd.search)
    else $error("item accepted without search");
`endif
endmodule
`default_nettype wire
